// ===== hdl/dspe_pkg.sv =====
// Shared constants, codes and types for the dual servo pulse and encoder counter block.
package dspe_pkg;

  localparam int TIMER_BITS = 16;
  localparam int PULSE_W    = 16;
  localparam int NEG_W      = (TIMER_BITS > PULSE_W) ? TIMER_BITS : PULSE_W;
  localparam int FRAME_W    = 8;
  localparam int CNT_W      = 16;
  localparam int NUM_ENC    = 4;
  localparam int FUNC_W     = 2;
  localparam int PINS_W     = 4;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FIELD_W = 2 + NUM_ENC * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  // encoder count slots, in pin order
  localparam int ENC_RIGHT_A = 0;
  localparam int ENC_RIGHT_B = 1;
  localparam int ENC_LEFT_B  = 2;
  localparam int ENC_LEFT_A  = 3;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_FINE  = 2'd0;
  localparam func_t FUNC_FRAME = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  localparam cfg_addr_t CFG_SERVO_ENABLE = 2'd0;
  localparam cfg_addr_t CFG_LEFT_PULSE   = 2'd1;
  localparam cfg_addr_t CFG_RIGHT_PULSE  = 2'd2;
  localparam cfg_addr_t CFG_FRAME_INTVL  = 2'd3;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 16'd3530;
  localparam logic [FRAME_W-1:0] FRAME_RESET = 8'h2C;

  typedef struct packed {
    logic               servo_enable;
    logic [PULSE_W-1:0] left_pulse_ticks;
    logic [PULSE_W-1:0] right_pulse_ticks;
    logic [FRAME_W-1:0] frame_intervals;
  } cfg_t;

  typedef struct packed {
    logic                            left_servo;
    logic                            right_servo;
    logic [NUM_ENC-1:0][CNT_W-1:0]   counts;
  } res_t;

endpackage

// ===== hdl/dspe_servo_core.sv =====
// Servo phase sequencer, pulse timer and encoder edge counters, one item per enabled cycle.
module dspe_servo_core import dspe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  func_t             func,
  input  logic [PINS_W-1:0] pins,
  input  cfg_t              cfg,
  output res_t              res_nxt
);

  logic [FRAME_W-1:0]            frame_cd_r, frame_cd_nxt;
  logic                          phase_right_r, phase_right_nxt;
  logic [TIMER_BITS-1:0]         timer_r, timer_nxt;
  logic                          running_r, running_nxt;
  logic                          left_r, left_nxt;
  logic                          right_r, right_nxt;
  logic [PINS_W-1:0]             prev_pins_r, prev_pins_nxt;
  logic [NUM_ENC-1:0][CNT_W-1:0] counts_r, counts_nxt;

  logic [FRAME_W-1:0]    cd_dec;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [PULSE_W-1:0]    load_ticks;
  logic [NEG_W-1:0]      load_neg;
  logic [PINS_W-1:0]     rising;

  assign timer_inc  = timer_r + TIMER_BITS'(1);
  assign cd_dec     = frame_cd_r - FRAME_W'(1);
  assign load_ticks = phase_right_r ? cfg.right_pulse_ticks : cfg.left_pulse_ticks;
  assign load_neg   = NEG_W'(0) - NEG_W'(load_ticks);
  assign rising     = ~prev_pins_r & pins;

  always_comb begin
    frame_cd_nxt    = frame_cd_r;
    phase_right_nxt = phase_right_r;
    timer_nxt       = timer_r;
    running_nxt     = running_r;
    left_nxt        = left_r;
    right_nxt       = right_r;
    prev_pins_nxt   = prev_pins_r;
    counts_nxt      = counts_r;
    case (func)
      FUNC_FINE: begin
        if (running_r) begin
          timer_nxt = timer_inc;
          // rollover ends the pulse on both sides
          if (timer_inc == '0) begin
            running_nxt = 1'b0;
            left_nxt    = 1'b0;
            right_nxt   = 1'b0;
          end
        end
      end
      FUNC_FRAME: begin
        if (cfg.servo_enable) begin
          frame_cd_nxt = cd_dec;
          if (cd_dec == '0) begin
            // phase start: raise one side, reload timer, sample encoders
            phase_right_nxt = ~phase_right_r;
            timer_nxt       = load_neg[TIMER_BITS-1:0];
            running_nxt     = 1'b1;
            if (phase_right_r) begin
              right_nxt = 1'b1;
            end else begin
              left_nxt = 1'b1;
            end
            frame_cd_nxt  = cfg.frame_intervals;
            prev_pins_nxt = pins;
            for (int k = 0; k < NUM_ENC; k++) begin
              if (rising[k]) begin
                counts_nxt[k] = counts_r[k] + CNT_W'(1);
              end
            end
          end
        end
      end
      FUNC_CLEAR: begin
        counts_nxt    = '0;
        prev_pins_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cd_r    <= FRAME_W'(1);
      phase_right_r <= 1'b0;
      timer_r       <= '0;
      running_r     <= 1'b0;
      left_r        <= 1'b0;
      right_r       <= 1'b0;
      prev_pins_r   <= '0;
      counts_r      <= '0;
    end else if (step_en) begin
      frame_cd_r    <= frame_cd_nxt;
      phase_right_r <= phase_right_nxt;
      timer_r       <= timer_nxt;
      running_r     <= running_nxt;
      left_r        <= left_nxt;
      right_r       <= right_nxt;
      prev_pins_r   <= prev_pins_nxt;
      counts_r      <= counts_nxt;
    end
  end

  assign res_nxt.left_servo  = left_nxt;
  assign res_nxt.right_servo = right_nxt;
  assign res_nxt.counts      = counts_nxt;

endmodule

// ===== hdl/dual_servo_pulse_encoder_counter_top.sv =====
// Top level: stream ports, configuration registers, input and result registers.
// Path: an accepted item passes through the input register, then the result register,
// before it shows on out_tvalid.
// Throughput: one item per clock while out_tready stays high; the single-pass update
// between the input register and the result register sets that figure.
// Reset: synchronous, active-low rst_n clears the pipeline valids, the servo state and
// the encoder counts, and loads the configuration registers with their default values.
module dual_servo_pulse_encoder_counter_top import dspe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // input items
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [3:0] encoder_pins, rest zero
  input  logic [FUNC_W-1:0]      in_tuser,   // [1:0] func
  // result items
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] left_servo, [1] right_servo, [17:2] count_right_a, [33:18] count_right_b,
  // [49:34] count_left_a, [65:50] count_left_b, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg_r;

  logic              in_valid_r;
  func_t             in_func_r;
  logic [PINS_W-1:0] in_pins_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic advance;
  res_t res_nxt;

  // configuration writes land directly; user sends them only while idle, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.servo_enable      <= 1'b0;
      cfg_r.left_pulse_ticks  <= PULSE_RESET;
      cfg_r.right_pulse_ticks <= PULSE_RESET;
      cfg_r.frame_intervals   <= FRAME_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_SERVO_ENABLE: cfg_r.servo_enable      <= cfg_wdata[0];
        CFG_LEFT_PULSE:   cfg_r.left_pulse_ticks  <= cfg_wdata[PULSE_W-1:0];
        CFG_RIGHT_PULSE:  cfg_r.right_pulse_ticks <= cfg_wdata[PULSE_W-1:0];
        CFG_FRAME_INTVL:  cfg_r.frame_intervals   <= cfg_wdata[FRAME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // advance the held item when the result register is free or being drained
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // input register: valid is control, payload holds without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser;
      in_pins_r <= in_tdata[PINS_W-1:0];
    end
  end

  // state update happens exactly once per item, when it moves into the result register
  dspe_servo_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .func    (in_func_r),
    .pins    (in_pins_r),
    .cfg     (cfg_r),
    .res_nxt (res_nxt)
  );

  // result register: hold until taken, load on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {{OUT_PAD_W{1'b0}},
                     res_nxt.counts[ENC_LEFT_B],
                     res_nxt.counts[ENC_LEFT_A],
                     res_nxt.counts[ENC_RIGHT_B],
                     res_nxt.counts[ENC_RIGHT_A],
                     res_nxt.right_servo,
                     res_nxt.left_servo};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
